// ===== rtl/core/nrtp_pkg.sv =====
// ----------------------------------------------------------------------------
// nrtp_pkg
// Shared widths, command codes, status codes and divider handshake types of the region timing profiler.
// ----------------------------------------------------------------------------
package nrtp_pkg;

   // Parameter defaults
   localparam int MAX_REGIONS_DEF = 128;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int TIME_BITS_DEF   = 32;

   // Fixed field widths
   localparam int CMD_W = 3;
   localparam int ID_W  = 7;
   localparam int TS_W  = 32;
   localparam int ST_W  = 3;
   localparam int CNT_W = 32;
   localparam int SUM_W = 48;
   localparam int OUT_W = 32;

   // Commands
   localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RESET    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

   // Status codes
   localparam logic [ST_W-1:0] ST_OK          = 3'd0;
   localparam logic [ST_W-1:0] ST_TABLE_FULL  = 3'd1;
   localparam logic [ST_W-1:0] ST_STACK_FULL  = 3'd2;
   localparam logic [ST_W-1:0] ST_STACK_EMPTY = 3'd3;
   localparam logic [ST_W-1:0] ST_UNREG       = 3'd4;

   // Handshake between sequencer and divider
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/core/nrtp_ram.sv =====
// ----------------------------------------------------------------------------
// nrtp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module nrtp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/nrtp_div.sv =====
// ----------------------------------------------------------------------------
// nrtp_div
// Restoring divider, one quotient bit a cycle, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module nrtp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  nrtp_pkg::div_ctrl_type      ctrl,
   input  logic [nrtp_pkg::SUM_W-1:0]  dividend,
   input  logic [nrtp_pkg::CNT_W-1:0]  divisor,
   output nrtp_pkg::div_stat_type      stat,
   output logic [nrtp_pkg::OUT_W-1:0]  quotient
);

   localparam int CW = nrtp_pkg::CNT_W;
   localparam int OW = nrtp_pkg::OUT_W;
   localparam int SW = nrtp_pkg::SUM_W;
   localparam int IW = $clog2(OW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [IW-1:0] iter_ff, iter_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [OW-1:0] quo_ff, quo_in;
   logic [CW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] top_part;
   logic [CW:0]   trial;
   logic          fits;

   assign top_part = CW'(dividend[SW-1:OW]);
   assign trial    = {rem_ff, quo_ff[OW-1]};
   assign fits     = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (ctrl.start) begin
         dvs_in = divisor;
         if (top_part >= divisor) begin
            // quotient needs more than 32 bits: clamp
            quo_in  = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = top_part;
            quo_in  = dividend[OW-1:0];
            iter_in = IW'(OW - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         if (fits) begin
            rem_in = CW'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[CW-1:0];
         end
         quo_in = {quo_ff[OW-2:0], fits};
         if (iter_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            iter_in = iter_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      iter_ff <= iter_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ===== rtl/core/nested_region_timing_profiler.sv =====
// ----------------------------------------------------------------------------
// nested_region_timing_profiler
// Region timing statistics with a nesting stack, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Register, errors and unknown commands skip the divider; push, query and pop
//   run the 32-step shared divider for the mean (not with no hits, and an
//   overflowing mean is clamped without the steps); reset stats clears count
//   and sum of each used slot in turn. A new word waits for the last result:
//   req_ready is high only while idle, and a finished result may wait in the
//   output register. Reset: synchronous, clears only state, fill counts, handshake.
// ----------------------------------------------------------------------------
module nested_region_timing_profiler #(
   parameter int MAX_REGIONS = nrtp_pkg::MAX_REGIONS_DEF,
   parameter int STACK_DEPTH = nrtp_pkg::STACK_DEPTH_DEF,
   parameter int TIME_BITS   = nrtp_pkg::TIME_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [nrtp_pkg::CMD_W-1:0]  req_command,
   input  logic [nrtp_pkg::ID_W-1:0]   req_region_id,
   input  logic [nrtp_pkg::TS_W-1:0]   req_timestamp,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [nrtp_pkg::ST_W-1:0]   rsp_status,
   output logic [nrtp_pkg::ID_W-1:0]   rsp_result_region,
   output logic [nrtp_pkg::CNT_W-1:0]  rsp_hit_count,
   output logic [nrtp_pkg::SUM_W-1:0]  rsp_total_ticks,
   output logic [nrtp_pkg::OUT_W-1:0]  rsp_shortest,
   output logic [nrtp_pkg::OUT_W-1:0]  rsp_longest,
   output logic [nrtp_pkg::OUT_W-1:0]  rsp_mean_ticks
);

   localparam int ID_W    = nrtp_pkg::ID_W;
   localparam int CNT_W   = nrtp_pkg::CNT_W;
   localparam int SUM_W   = nrtp_pkg::SUM_W;
   localparam int OUT_W   = nrtp_pkg::OUT_W;
   localparam int SLOT_W  = $clog2(MAX_REGIONS);
   localparam int USED_W  = $clog2(MAX_REGIONS + 1);
   localparam int SP_W    = $clog2(STACK_DEPTH);
   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W   = (USED_W > ID_W) ? USED_W : ID_W;
   localparam int CS_W    = CNT_W + SUM_W;
   localparam int MM_W    = 2 * TIME_BITS;
   localparam int STK_W   = ID_W + TIME_BITS;

   // Sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_POP_STK   = 4'd2;
   localparam logic [3:0] S_STATS     = 4'd3;
   localparam logic [3:0] S_UPDATE    = 4'd4;
   localparam logic [3:0] S_SWEEP     = 4'd5;
   localparam logic [3:0] S_DIV_START = 4'd6;
   localparam logic [3:0] S_DIV_WAIT  = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;

   logic [3:0] state_ff, state_in;

   // Captured word
   logic [nrtp_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [ID_W-1:0]            id_ff, id_in;
   logic [TIME_BITS-1:0]       ts_ff, ts_in;

   // Fill counts
   logic [USED_W-1:0]  used_ff, used_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [USED_W-1:0]  sweep_ff, sweep_in;

   // Working statistics of the region in hand
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [TIME_BITS-1:0] dur_ff, dur_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [TIME_BITS-1:0] min_ff, min_in;
   logic [TIME_BITS-1:0] max_ff, max_in;
   logic [OUT_W-1:0]     mean_ff, mean_in;
   logic [nrtp_pkg::ST_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]      region_ff, region_in;
   logic                 has_stats_ff, has_stats_in;

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [nrtp_pkg::ST_W-1:0] o_status_ff, o_status_in;
   logic [ID_W-1:0]           o_region_ff, o_region_in;
   logic [CNT_W-1:0]          o_cnt_ff, o_cnt_in;
   logic [SUM_W-1:0]          o_sum_ff, o_sum_in;
   logic [OUT_W-1:0]          o_min_ff, o_min_in;
   logic [OUT_W-1:0]          o_max_ff, o_max_in;
   logic [OUT_W-1:0]          o_mean_ff, o_mean_in;

   // Memory ports
   logic              cs_we, mm_we, stk_we;
   logic [SLOT_W-1:0] cs_wa, mm_wa, stats_ra;
   logic [CS_W-1:0]   cs_wd, cs_rd;
   logic [MM_W-1:0]   mm_wd, mm_rd;
   logic [SP_W-1:0]   stk_wa, stk_ra;
   logic [STK_W-1:0]  stk_wd, stk_rd;

   // Divider
   nrtp_pkg::div_ctrl_type div_ctrl;
   nrtp_pkg::div_stat_type div_stat;
   logic [OUT_W-1:0]       div_quo;

   // Update arithmetic
   logic [CNT_W-1:0]     rd_cnt;
   logic [SUM_W-1:0]     rd_sum;
   logic [TIME_BITS-1:0] rd_min, rd_max;
   logic [SUM_W:0]       sum_add;
   logic [CNT_W-1:0]     cnt_upd;
   logic [SUM_W-1:0]     sum_upd;
   logic [TIME_BITS-1:0] min_upd, max_upd;
   logic                 id_known;
   logic [SUM_W-1:0]     min_wide, max_wide;
   logic                 load_out;

   assign rd_cnt = cs_rd[CS_W-1:SUM_W];
   assign rd_sum = cs_rd[SUM_W-1:0];
   assign rd_min = mm_rd[MM_W-1:TIME_BITS];
   assign rd_max = mm_rd[TIME_BITS-1:0];

   // Fold the duration in, saturating count and sum
   assign sum_add = {1'b0, rd_sum} + (SUM_W + 1)'(dur_ff);
   assign sum_upd = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
   assign cnt_upd = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
   assign min_upd = (dur_ff < rd_min) ? dur_ff : rd_min;
   assign max_upd = (dur_ff > rd_max) ? dur_ff : rd_max;

   assign id_known = CMP_W'(id_ff) < CMP_W'(used_ff);

   // Clamp durations to 32 bits on the way out
   assign min_wide = SUM_W'(min_ff);
   assign max_wide = SUM_W'(max_ff);

   assign load_out = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      ts_in        = ts_ff;
      used_in      = used_ff;
      depth_in     = depth_ff;
      sweep_in     = sweep_ff;
      slot_in      = slot_ff;
      dur_in       = dur_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      mean_in      = mean_ff;
      status_in    = status_ff;
      region_in    = region_ff;
      has_stats_in = has_stats_ff;
      cs_we        = 1'b0;
      cs_wa        = slot_ff;
      cs_wd        = '0;
      mm_we        = 1'b0;
      mm_wa        = slot_ff;
      mm_wd        = {min_upd, max_upd};
      stk_we       = 1'b0;
      stk_wa       = SP_W'(depth_ff);
      stk_wd       = {id_ff, ts_ff};
      stk_ra       = SP_W'(depth_ff - 1'b1);
      stats_ra     = SLOT_W'(id_ff);
      div_ctrl     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               id_in    = req_region_id;
               ts_in    = TIME_BITS'(req_timestamp);
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            status_in    = nrtp_pkg::ST_OK;
            region_in    = '0;
            has_stats_in = 1'b0;
            mean_in      = '0;
            state_in     = S_DONE;
            case (cmd_ff)
               nrtp_pkg::CMD_REGISTER: begin
                  if (used_ff == USED_W'(MAX_REGIONS)) begin
                     status_in = nrtp_pkg::ST_TABLE_FULL;
                  end else begin
                     // seed a fresh slot: empty sums, min all ones
                     cs_we        = 1'b1;
                     cs_wa        = SLOT_W'(used_ff);
                     cs_wd        = '0;
                     mm_we        = 1'b1;
                     mm_wa        = SLOT_W'(used_ff);
                     mm_wd        = {{TIME_BITS{1'b1}}, {TIME_BITS{1'b0}}};
                     cnt_in       = '0;
                     sum_in       = '0;
                     min_in       = '1;
                     max_in       = '0;
                     region_in    = ID_W'(used_ff);
                     used_in      = used_ff + 1'b1;
                     has_stats_in = 1'b1;
                  end
               end
               nrtp_pkg::CMD_PUSH: begin
                  region_in = id_ff;
                  if (!id_known) begin
                     status_in = nrtp_pkg::ST_UNREG;
                  end else if (depth_ff == DEPTH_W'(STACK_DEPTH)) begin
                     status_in = nrtp_pkg::ST_STACK_FULL;
                  end else begin
                     stk_we       = 1'b1;
                     depth_in     = depth_ff + 1'b1;
                     has_stats_in = 1'b1;
                     state_in     = S_STATS;
                  end
               end
               nrtp_pkg::CMD_POP: begin
                  if (depth_ff == '0) begin
                     status_in = nrtp_pkg::ST_STACK_EMPTY;
                  end else begin
                     depth_in = depth_ff - 1'b1;
                     state_in = S_POP_STK;
                  end
               end
               nrtp_pkg::CMD_RESET: begin
                  depth_in = '0;
                  sweep_in = '0;
                  if (used_ff != '0) begin
                     state_in = S_SWEEP;
                  end
               end
               nrtp_pkg::CMD_QUERY: begin
                  region_in = id_ff;
                  if (!id_known) begin
                     status_in = nrtp_pkg::ST_UNREG;
                  end else begin
                     has_stats_in = 1'b1;
                     state_in     = S_STATS;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_POP_STK: begin
            // top of stack is out: work out the duration, fetch the slot
            region_in    = stk_rd[STK_W-1:TIME_BITS];
            slot_in      = SLOT_W'(stk_rd[STK_W-1:TIME_BITS]);
            stats_ra     = SLOT_W'(stk_rd[STK_W-1:TIME_BITS]);
            dur_in       = ts_ff - stk_rd[TIME_BITS-1:0];
            has_stats_in = 1'b1;
            state_in     = S_UPDATE;
         end
         S_STATS: begin
            cnt_in   = rd_cnt;
            sum_in   = rd_sum;
            min_in   = rd_min;
            max_in   = rd_max;
            state_in = S_DIV_START;
         end
         S_UPDATE: begin
            cs_we    = 1'b1;
            cs_wd    = {cnt_upd, sum_upd};
            mm_we    = 1'b1;
            cnt_in   = cnt_upd;
            sum_in   = sum_upd;
            min_in   = min_upd;
            max_in   = max_upd;
            state_in = S_DIV_START;
         end
         S_SWEEP: begin
            // clear count and sum, one slot a cycle; min and max stay
            cs_we = 1'b1;
            cs_wa = SLOT_W'(sweep_ff);
            cs_wd = '0;
            if (sweep_ff == used_ff - 1'b1) begin
               state_in = S_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_DIV_START: begin
            if (cnt_ff == '0) begin
               mean_in  = '0;
               state_in = S_DONE;
            end else begin
               div_ctrl.start = 1'b1;
               state_in       = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_stat.done) begin
               mean_in  = div_quo;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: drop on take, load when the sequencer finishes
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_status_in  = o_status_ff;
      o_region_in  = o_region_ff;
      o_cnt_in     = o_cnt_ff;
      o_sum_in     = o_sum_ff;
      o_min_in     = o_min_ff;
      o_max_in     = o_max_ff;
      o_mean_in    = o_mean_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         o_status_in  = status_ff;
         o_region_in  = region_ff;
         o_cnt_in     = '0;
         o_sum_in     = '0;
         o_min_in     = '0;
         o_max_in     = '0;
         o_mean_in    = '0;
         if (has_stats_ff) begin
            o_cnt_in  = cnt_ff;
            o_sum_in  = sum_ff;
            o_min_in  = (min_wide > SUM_W'({OUT_W{1'b1}})) ? '1 : min_wide[OUT_W-1:0];
            o_max_in  = (max_wide > SUM_W'({OUT_W{1'b1}})) ? '1 : max_wide[OUT_W-1:0];
            o_mean_in = mean_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      ts_ff        <= ts_in;
      sweep_ff     <= sweep_in;
      slot_ff      <= slot_in;
      dur_ff       <= dur_in;
      cnt_ff       <= cnt_in;
      sum_ff       <= sum_in;
      min_ff       <= min_in;
      max_ff       <= max_in;
      mean_ff      <= mean_in;
      status_ff    <= status_in;
      region_ff    <= region_in;
      has_stats_ff <= has_stats_in;
      o_status_ff  <= o_status_in;
      o_region_ff  <= o_region_in;
      o_cnt_ff     <= o_cnt_in;
      o_sum_ff     <= o_sum_in;
      o_min_ff     <= o_min_in;
      o_max_ff     <= o_max_in;
      o_mean_ff    <= o_mean_in;
   end

   // Count and sum per region
   nrtp_ram #(
      .WIDTH (CS_W),
      .DEPTH (MAX_REGIONS)
   ) u_cs_ram (
      .clock   (clock),
      .wr_en   (cs_we),
      .wr_addr (cs_wa),
      .wr_data (cs_wd),
      .rd_addr (stats_ra),
      .rd_data (cs_rd)
   );

   // Min and max per region
   nrtp_ram #(
      .WIDTH (MM_W),
      .DEPTH (MAX_REGIONS)
   ) u_mm_ram (
      .clock   (clock),
      .wr_en   (mm_we),
      .wr_addr (mm_wa),
      .wr_data (mm_wd),
      .rd_addr (stats_ra),
      .rd_data (mm_rd)
   );

   // Open region stack: id and start time
   nrtp_ram #(
      .WIDTH (STK_W),
      .DEPTH (STACK_DEPTH)
   ) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   // Mean of the region in hand
   nrtp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = o_status_ff;
   assign rsp_result_region = o_region_ff;
   assign rsp_hit_count     = o_cnt_ff;
   assign rsp_total_ticks   = o_sum_ff;
   assign rsp_shortest      = o_min_ff;
   assign rsp_longest       = o_max_ff;
   assign rsp_mean_ticks    = o_mean_ff;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nested region timing profiler. Words go in on the
// req_ channel with random gaps. A predictor follows the region table and the
// nesting stack and queues one expected word for each accepted request. Each
// rsp_ word is checked field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CMD_W         = nrtp_pkg::CMD_W;
   localparam int     ID_W          = nrtp_pkg::ID_W;
   localparam int     TS_W          = nrtp_pkg::TS_W;
   localparam int     ST_W          = nrtp_pkg::ST_W;
   localparam int     CNT_W         = nrtp_pkg::CNT_W;
   localparam int     SUM_W         = nrtp_pkg::SUM_W;
   localparam int     OUT_W         = nrtp_pkg::OUT_W;
   localparam int     REGION_SLOTS  = nrtp_pkg::MAX_REGIONS_DEF;
   localparam int     NEST_LIMIT    = nrtp_pkg::STACK_DEPTH_DEF;
   localparam int     IDLE_PCT      = 24;
   localparam int     HOLD_CYCLES   = 400;
   localparam int     SETTLE_CYCLES = 200;
   localparam int     RANDOM_WORDS  = 1570;
   localparam longint CYCLE_LIMIT   = 4_000_000;

   localparam logic [SUM_W-1:0] SUM_CEILING = '1;
   localparam logic [CNT_W-1:0] HIT_CEILING = '1;

   // One response word as the block should present it
   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [ID_W-1:0]  region;
      logic [CNT_W-1:0] hits;
      logic [SUM_W-1:0] total;
      logic [OUT_W-1:0] shortest;
      logic [OUT_W-1:0] longest;
      logic [OUT_W-1:0] mean;
   } profile_word_type;

   // Every input of the block is known from time zero
   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             req_valid     = 1'b0;
   logic [CMD_W-1:0] req_command   = '0;
   logic [ID_W-1:0]  req_region_id = '0;
   logic [TS_W-1:0]  req_timestamp = '0;
   logic             rsp_ready     = 1'b0;

   logic             req_ready;
   logic             rsp_valid;
   logic [ST_W-1:0]  rsp_status;
   logic [ID_W-1:0]  rsp_result_region;
   logic [CNT_W-1:0] rsp_hit_count;
   logic [SUM_W-1:0] rsp_total_ticks;
   logic [OUT_W-1:0] rsp_shortest;
   logic [OUT_W-1:0] rsp_longest;
   logic [OUT_W-1:0] rsp_mean_ticks;

   // Predicted region table and nesting stack
   logic [CNT_W-1:0] region_hits     [REGION_SLOTS];
   logic [SUM_W-1:0] region_totals   [REGION_SLOTS];
   logic [TS_W-1:0]  region_shortest [REGION_SLOTS];
   logic [TS_W-1:0]  region_longest  [REGION_SLOTS];
   int               slots_taken = 0;
   logic [ID_W-1:0]  open_region [NEST_LIMIT];
   logic [TS_W-1:0]  open_start  [NEST_LIMIT];
   int               nest_depth = 0;

   profile_word_type profile_q [$];
   profile_word_type want_word;
   int               status_seen [8] = '{default: 0};
   int               mismatches  = 0;
   int               words_sent  = 0;
   int               words_seen  = 0;
   longint           cycle_count = 0;
   logic [TS_W-1:0]  tick_now    = '0;

   // Idling is switched off while calm is set; hold-offs are asked by count
   bit               calm          = 1'b0;
   int               hold_requests = 0;
   int               hold_served   = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   nested_region_timing_profiler u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_region_id     (req_region_id),
      .req_timestamp     (req_timestamp),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_result_region (rsp_result_region),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_total_ticks   (rsp_total_ticks),
      .rsp_shortest      (rsp_shortest),
      .rsp_longest       (rsp_longest),
      .rsp_mean_ticks    (rsp_mean_ticks)
   );

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Statistics of one slot as reported after a successful command
   function automatic profile_word_type stats_word(input int slot);
      profile_word_type w;
      logic [SUM_W-1:0] quotient;
      w          = '0;
      w.status   = nrtp_pkg::ST_OK;
      w.region   = slot[ID_W-1:0];
      w.hits     = region_hits[slot];
      w.total    = region_totals[slot];
      w.shortest = region_shortest[slot];
      w.longest  = region_longest[slot];
      if (region_hits[slot] != '0) begin
         quotient = region_totals[slot] / region_hits[slot];
         // clamp the mean to the output width
         w.mean   = (quotient[SUM_W-1:OUT_W] != '0) ? '1 : quotient[OUT_W-1:0];
      end
      return w;
   endfunction

   // Advance the predicted state by one request and return the word it causes
   function automatic profile_word_type predict_profile(input logic [CMD_W-1:0] op,
                                                        input logic [ID_W-1:0]  id,
                                                        input logic [TS_W-1:0]  ts);
      profile_word_type w;
      logic [TS_W-1:0]  span;
      logic [SUM_W:0]   grown;
      int               slot;
      w = '0;
      case (op)
         nrtp_pkg::CMD_REGISTER: begin
            if (slots_taken >= REGION_SLOTS) begin
               w.status = nrtp_pkg::ST_TABLE_FULL;
            end else begin
               slot                  = slots_taken;
               region_hits[slot]     = '0;
               region_totals[slot]   = '0;
               region_shortest[slot] = '1;
               region_longest[slot]  = '0;
               slots_taken++;
               w = stats_word(slot);
            end
         end
         nrtp_pkg::CMD_PUSH: begin
            // an unknown slot is reported ahead of a full stack
            if (int'(id) >= slots_taken) begin
               w.status = nrtp_pkg::ST_UNREG;
               w.region = id;
            end else if (nest_depth >= NEST_LIMIT) begin
               w.status = nrtp_pkg::ST_STACK_FULL;
               w.region = id;
            end else begin
               open_region[nest_depth] = id;
               open_start[nest_depth]  = ts;
               nest_depth++;
               w = stats_word(int'(id));
            end
         end
         nrtp_pkg::CMD_POP: begin
            if (nest_depth == 0) begin
               w.status = nrtp_pkg::ST_STACK_EMPTY;
            end else begin
               nest_depth--;
               slot = int'(open_region[nest_depth]);
               // elapsed ticks wrap at the timestamp width
               span = ts - open_start[nest_depth];
               if (region_hits[slot] != HIT_CEILING) begin
                  region_hits[slot]++;
               end
               grown = {1'b0, region_totals[slot]} + (SUM_W + 1)'(span);
               region_totals[slot] = grown[SUM_W] ? SUM_CEILING : grown[SUM_W-1:0];
               if (span < region_shortest[slot]) begin
                  region_shortest[slot] = span;
               end
               if (span > region_longest[slot]) begin
                  region_longest[slot] = span;
               end
               w = stats_word(slot);
            end
         end
         nrtp_pkg::CMD_RESET: begin
            // shortest and longest survive a statistics reset
            for (int i = 0; i < slots_taken; i++) begin
               region_totals[i] = '0;
               region_hits[i]   = '0;
            end
            nest_depth = 0;
         end
         nrtp_pkg::CMD_QUERY: begin
            if (int'(id) >= slots_taken) begin
               w.status = nrtp_pkg::ST_UNREG;
               w.region = id;
            end else begin
               w = stats_word(int'(id));
            end
         end
         default: begin
         end
      endcase
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Mostly short steps, now and then a long jump or a fresh random time
   function automatic logic [TS_W-1:0] next_tick();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) begin
         tick_now = $urandom;
      end else if (roll < 15) begin
         tick_now += $urandom;
      end else begin
         tick_now += $urandom_range(400);
      end
      return tick_now;
   endfunction

   // A registered slot most of the time, any slot now and then
   function automatic logic [ID_W-1:0] pick_region();
      if (slots_taken == 0 || $urandom_range(9) == 0) begin
         return ID_W'($urandom);
      end
      return ID_W'($urandom_range(slots_taken - 1));
   endfunction

   // Offer one word and hold it until taken; entered and left at a falling edge.
   // Valid is left high so that the next word can follow without a dip.
   task automatic send_word(input logic [CMD_W-1:0] op,
                            input logic [ID_W-1:0]  id,
                            input logic [TS_W-1:0]  ts);
      profile_word_type w;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= op;
      req_region_id <= id;
      req_timestamp <= ts;
      do @(posedge clock); while (req_ready !== 1'b1);
      w = predict_profile(op, id, ts);
      profile_q.push_back(w);
      status_seen[w.status]++;
      words_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected word has come back
   task automatic await_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (profile_q.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Before any region exists: unknown slots, empty stack, unknown commands
   task automatic test_unregistered_and_empty();
      send_word(nrtp_pkg::CMD_PUSH, '0, next_tick());
      send_word(nrtp_pkg::CMD_QUERY, '1, next_tick());
      send_word(nrtp_pkg::CMD_POP, '1, next_tick());
      send_word(nrtp_pkg::CMD_RESET, '1, '1);
      send_word(3'd5, '1, '1);
      send_word(3'd6, '0, '0);
      send_word(3'd7, ID_W'($urandom), $urandom);
   endtask

   // Nesting, wrapped time, zero and longest spans, statistics reset
   task automatic test_basic_timing();
      repeat (3) send_word(nrtp_pkg::CMD_REGISTER, '0, next_tick());
      send_word(nrtp_pkg::CMD_QUERY, ID_W'(2), next_tick());
      send_word(nrtp_pkg::CMD_QUERY, ID_W'(3), next_tick());
      send_word(nrtp_pkg::CMD_PUSH, ID_W'(0), 32'd100);
      send_word(nrtp_pkg::CMD_PUSH, ID_W'(1), 32'd150);
      send_word(nrtp_pkg::CMD_POP, ID_W'(0), 32'd400);
      send_word(nrtp_pkg::CMD_POP, ID_W'(0), 32'd1000);
      // the close comes after the counter has wrapped
      send_word(nrtp_pkg::CMD_PUSH, ID_W'(2), 32'hFFFF_FFF0);
      send_word(nrtp_pkg::CMD_POP, ID_W'(0), 32'h0000_0010);
      send_word(nrtp_pkg::CMD_PUSH, ID_W'(2), 32'd5);
      send_word(nrtp_pkg::CMD_POP, '1, 32'd5);
      // one tick short of a full wrap gives the longest span
      send_word(nrtp_pkg::CMD_PUSH, ID_W'(1), 32'd1);
      send_word(nrtp_pkg::CMD_POP, ID_W'(0), 32'd0);
      send_word(nrtp_pkg::CMD_QUERY, ID_W'(1), next_tick());
      send_word(nrtp_pkg::CMD_QUERY, ID_W'(2), next_tick());
      send_word(nrtp_pkg::CMD_RESET, ID_W'(0), next_tick());
      send_word(nrtp_pkg::CMD_QUERY, ID_W'(1), next_tick());
      send_word(nrtp_pkg::CMD_PUSH, ID_W'(0), 32'hFFFF_FFFF);
      send_word(nrtp_pkg::CMD_POP, ID_W'(0), 32'hFFFF_FFFF);
      send_word(nrtp_pkg::CMD_QUERY, ID_W'(0), next_tick());
   endtask

   // Fill the stack, overflow it, then drop what is left with a reset
   task automatic test_stack_overflow();
      while (nest_depth < NEST_LIMIT) begin
         send_word(nrtp_pkg::CMD_PUSH, ID_W'($urandom_range(slots_taken - 1)),
                   next_tick());
      end
      send_word(nrtp_pkg::CMD_PUSH, ID_W'(0), next_tick());
      send_word(nrtp_pkg::CMD_PUSH, ID_W'(slots_taken), next_tick());
      send_word(nrtp_pkg::CMD_QUERY, ID_W'(1), next_tick());
      repeat (4) send_word(nrtp_pkg::CMD_POP, ID_W'($urandom), next_tick());
      send_word(nrtp_pkg::CMD_RESET, ID_W'(0), next_tick());
      send_word(nrtp_pkg::CMD_POP, ID_W'(0), next_tick());
      send_word(nrtp_pkg::CMD_QUERY, ID_W'(0), next_tick());
   endtask

   // Keep offering words while the response side holds off for a long stretch
   task automatic test_output_backpressure();
      hold_requests++;
      repeat (6) begin
         send_word(nrtp_pkg::CMD_PUSH, ID_W'($urandom_range(slots_taken - 1)),
                   next_tick());
         send_word(nrtp_pkg::CMD_QUERY, pick_region(), next_tick());
         send_word(nrtp_pkg::CMD_POP, '0, next_tick());
      end
   endtask

   // Mostly nested open and close runs with random content, plus queries,
   // growth of the table, resets, broken runs and raw noise
   task automatic test_random_nesting();
      int target;
      int depth;
      int closes;
      int roll;
      int done;
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         done = words_sent + RANDOM_WORDS - target;
         // a stretch with no idling on either side
         calm = (done >= 700) && (done < 1000);
         roll = $urandom_range(99);
         if (roll < 60) begin
            depth = ($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
            for (int k = 0; k < depth; k++) begin
               send_word(nrtp_pkg::CMD_PUSH, pick_region(), next_tick());
               if ($urandom_range(7) == 0) begin
                  send_word(nrtp_pkg::CMD_QUERY, pick_region(), next_tick());
               end
            end
            // sometimes leave one open, sometimes close one too many
            roll   = $urandom_range(9);
            closes = (roll == 0) ? depth - 1 : (roll == 1) ? depth + 1 : depth;
            for (int k = 0; k < closes; k++) begin
               send_word(nrtp_pkg::CMD_POP, ID_W'($urandom), next_tick());
            end
         end else if (roll < 75) begin
            send_word(nrtp_pkg::CMD_QUERY, pick_region(), next_tick());
         end else if (roll < 80) begin
            send_word(nrtp_pkg::CMD_REGISTER, ID_W'($urandom), next_tick());
         end else if (roll < 83) begin
            send_word(nrtp_pkg::CMD_RESET, ID_W'($urandom), next_tick());
         end else begin
            send_word(CMD_W'($urandom), ID_W'($urandom), $urandom);
         end
      end
      calm = 1'b0;
   endtask

   // Take every slot, register past the end, then use the top slots
   task automatic test_table_full();
      while (slots_taken < REGION_SLOTS) begin
         send_word(nrtp_pkg::CMD_REGISTER, ID_W'($urandom), next_tick());
      end
      repeat (3) send_word(nrtp_pkg::CMD_REGISTER, ID_W'($urandom), next_tick());
      send_word(nrtp_pkg::CMD_PUSH, '1, next_tick());
      send_word(nrtp_pkg::CMD_POP, ID_W'(0), next_tick());
      send_word(nrtp_pkg::CMD_QUERY, '1, next_tick());
      repeat (10) begin
         send_word(nrtp_pkg::CMD_PUSH, ID_W'($urandom), next_tick());
         send_word(nrtp_pkg::CMD_QUERY, ID_W'($urandom), next_tick());
         send_word(nrtp_pkg::CMD_POP, ID_W'($urandom), next_tick());
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls, plus a long counted hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            rsp_ready  <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Check every accepted response word against the oldest expectation
   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         words_seen++;
         if (profile_q.size() == 0) begin
            mismatches++;
            $error("response word with nothing expected, rsp_status 0x%0h", rsp_status);
         end else begin
            want_word = profile_q.pop_front();
            check_field("rsp_status", 64'(want_word.status), 64'(rsp_status));
            check_field("rsp_result_region", 64'(want_word.region), 64'(rsp_result_region));
            check_field("rsp_hit_count", 64'(want_word.hits), 64'(rsp_hit_count));
            check_field("rsp_total_ticks", 64'(want_word.total), 64'(rsp_total_ticks));
            check_field("rsp_shortest", 64'(want_word.shortest), 64'(rsp_shortest));
            check_field("rsp_longest", 64'(want_word.longest), 64'(rsp_longest));
            check_field("rsp_mean_ticks", 64'(want_word.mean), 64'(rsp_mean_ticks));
         end
      end
   end

   // Hard stop if the block hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped after %0d cycles, %0d words still owed",
               cycle_count, profile_q.size());
      $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Sequence of tests
   // ------------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unregistered_and_empty();
      await_results();
      test_basic_timing();
      await_results();
      test_stack_overflow();
      await_results();
      test_output_backpressure();
      await_results();
      test_random_nesting();
      await_results();
      test_table_full();
      await_results();

      // catch any stray word after the last expected one
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("%0d requests, %0d responses checked in %0d cycles, %0d slots registered",
               words_sent, words_seen, cycle_count, slots_taken);
      $display("statuses seen: ok %0d, table full %0d, stack full %0d, empty %0d, unknown %0d",
               status_seen[nrtp_pkg::ST_OK], status_seen[nrtp_pkg::ST_TABLE_FULL],
               status_seen[nrtp_pkg::ST_STACK_FULL], status_seen[nrtp_pkg::ST_STACK_EMPTY],
               status_seen[nrtp_pkg::ST_UNREG]);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/nrtp_pkg.sv
rtl/core/nrtp_ram.sv
rtl/core/nrtp_div.sv
rtl/core/nested_region_timing_profiler.sv
tb/tb_top.sv
